// ----- hdl/bec_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Buffer energy current limiter package
// Shared word types, register indexes, constants and the buffer ratio table.
// ----------------------------------------------------------------------------
package bec_pkg;

    localparam int MOTORS     = 4;
    localparam int CUR_W      = 16;
    localparam int MAG_W      = CUR_W + 1;
    localparam int SUM_W      = MAG_W + 1;
    localparam int BUF_W      = 10;
    localparam int FULL_W     = 16;
    localparam int BUF_FULL   = 60;
    localparam int BUF_SQUARE = 25;
    localparam int BUF_IDX_W  = $clog2(BUF_FULL);
    localparam int TAB_DEPTH  = 2 ** BUF_IDX_W;
    localparam int FRAC_W     = 16;
    localparam int RATIO_W    = FRAC_W + 1;
    localparam int DIV_STEPS_PER_STAGE = 3;
    localparam int DIV_STAGES =
        (RATIO_W + DIV_STEPS_PER_STAGE - 1) / DIV_STEPS_PER_STAGE;

    // Configuration register indexes
    localparam logic REG_LIMIT_ENABLE = 1'b0;
    localparam logic REG_FULL_OUTPUT  = 1'b1;

    localparam logic [FULL_W-1:0] FULL_OUTPUT_RESET = 16'd32000;

    typedef logic [TAB_DEPTH-1:0][FRAC_W-1:0] ktab_t;

    // Budget factor per clamped buffer level: buffer/60 in Q0.16, squared
    // below the square threshold. Entries from 60 upwards are never used.
    function automatic ktab_t k2_table_f();
        ktab_t       t;
        logic [31:0] k;
        t = '0;
        for (int i = 0; i < BUF_FULL; i++)
        begin
            k = (32'(i) << FRAC_W) / BUF_FULL;
            if (i < BUF_SQUARE)
            begin
                k = (k * k) >> FRAC_W;
            end
            t[i] = k[FRAC_W-1:0];
        end
        return t;
    endfunction

    localparam ktab_t K2_TABLE = k2_table_f();

    typedef struct packed {
        logic [BUF_W-1:0]        buffer_energy;
        logic signed [CUR_W-1:0] current_left_front;
        logic signed [CUR_W-1:0] current_right_front;
        logic signed [CUR_W-1:0] current_left_back;
        logic signed [CUR_W-1:0] current_right_back;
    } cmd_t;

    typedef struct packed {
        logic signed [CUR_W-1:0] limited_left_front;
        logic signed [CUR_W-1:0] limited_right_front;
        logic signed [CUR_W-1:0] limited_left_back;
        logic signed [CUR_W-1:0] limited_right_back;
        logic                    was_scaled;
    } lim_t;

    typedef struct packed {
        logic              limit_enable;
        logic [FULL_W-1:0] full_output;
    } cfg_t;

    typedef struct packed {
        logic [MOTORS-1:0][CUR_W-1:0] cur;
        logic [MOTORS-1:0][MAG_W-1:0] mag;
        logic [SUM_W-1:0]             sum;
        logic [FULL_W-1:0]            budget;
        logic                         scaled;
    } front_t;

    typedef struct packed {
        logic [MOTORS-1:0][CUR_W-1:0] cur;
        logic [MOTORS-1:0][MAG_W-1:0] mag;
        logic [RATIO_W-1:0]           ratio;
        logic                         scaled;
    } ratio_t;

endpackage

// ----- hdl/bec_stream_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stream interface
// Valid/ready channel carrying one word of a chosen payload type.
// ----------------------------------------------------------------------------
interface bec_stream_if #(
    parameter type data_t = logic
);
    logic  valid;
    logic  ready;
    data_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ----- hdl/buffer_energy_current_limiter.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Buffer energy current limiter
// Scales four motor currents so their summed magnitude respects a budget
// derived from the remaining power-buffer energy.
// ----------------------------------------------------------------------------
// Usage:
// Command words (buffer energy and four signed currents) arrive on cmd; one
// limited word (four currents and a scaled flag) leaves on lim per command.
// Both channels move a word when valid and ready are high at a clock edge.
// The cfg port writes limit_enable (index 0) and full_output (index 1);
// write it only while no word is in flight.
// The pipeline has three front-end stages (magnitudes and table lookup,
// sum and budget multiply, compare), six divider stages resolving three
// quotient bits each (two in the last), and two stages for the scale
// multiply and sign restore.
// Throughput is one word per cycle while lim is ready; every stage holds
// its own valid bit. When lim is stalled the pipeline keeps filling its
// empty stages, and cmd.ready drops only once every stage holds a word.
// Reset empties the pipeline and loads limit_enable = 1, full_output = 32000.
// ----------------------------------------------------------------------------
module buffer_energy_current_limiter (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_we,
    input  logic         cfg_index,
    input  logic [15:0]  cfg_wdata,
    bec_stream_if.sink   cmd,
    bec_stream_if.source lim
);

    logic                       limit_enable_reg;
    logic [bec_pkg::FULL_W-1:0] full_output_reg;
    bec_pkg::cfg_t              cfg;

    bec_stream_if #(.data_t(bec_pkg::front_t)) front_link ();
    bec_stream_if #(.data_t(bec_pkg::ratio_t)) ratio_link ();

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_enable_reg <= 1'b1;
            full_output_reg  <= bec_pkg::FULL_OUTPUT_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                bec_pkg::REG_LIMIT_ENABLE: limit_enable_reg <= cfg_wdata[0];
                bec_pkg::REG_FULL_OUTPUT:  full_output_reg  <= cfg_wdata;
                default:
                begin
                end
            endcase
        end
    end

    assign cfg.limit_enable = limit_enable_reg;
    assign cfg.full_output  = full_output_reg;

    bec_front u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .cmd   (cmd),
        .fwd   (front_link.source)
    );

    bec_divider u_divider (
        .clk   (clk),
        .rst_n (rst_n),
        .fwd   (front_link.sink),
        .rat   (ratio_link.source)
    );

    bec_scale u_scale (
        .clk   (clk),
        .rst_n (rst_n),
        .rat   (ratio_link.sink),
        .lim   (lim)
    );

endmodule

// ----- hdl/bec_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Limiter front end
// Magnitudes, summed current, buffer budget and the scaling decision.
// ----------------------------------------------------------------------------
module bec_front (
    input  logic          clk,
    input  logic          rst_n,
    input  bec_pkg::cfg_t cfg,
    bec_stream_if.sink    cmd,
    bec_stream_if.source  fwd
);

    typedef struct packed {
        logic [bec_pkg::MOTORS-1:0][bec_pkg::CUR_W-1:0] cur;
        logic [bec_pkg::MOTORS-1:0][bec_pkg::MAG_W-1:0] mag;
        logic [bec_pkg::FRAC_W-1:0]                     kk;
        logic                                           full;
    } f1_t;

    typedef struct packed {
        logic [bec_pkg::MOTORS-1:0][bec_pkg::CUR_W-1:0] cur;
        logic [bec_pkg::MOTORS-1:0][bec_pkg::MAG_W-1:0] mag;
        logic [bec_pkg::SUM_W-1:0]                      sum;
        logic [bec_pkg::FULL_W-1:0]                     budget;
    } f2_t;

    f1_t             s1_reg, s1_next;
    f2_t             s2_reg, s2_next;
    bec_pkg::front_t s3_reg, s3_next;
    logic            v1_reg, v2_reg, v3_reg;
    logic            adv1, adv2, adv3;
    logic [2*bec_pkg::FULL_W-1:0] prod;

    assign adv3 = !v3_reg || fwd.ready;
    assign adv2 = !v2_reg || adv3;
    assign adv1 = !v1_reg || adv2;
    assign cmd.ready = adv1;

    always_comb
    begin
        s1_next.cur[0] = cmd.data.current_left_front;
        s1_next.cur[1] = cmd.data.current_right_front;
        s1_next.cur[2] = cmd.data.current_left_back;
        s1_next.cur[3] = cmd.data.current_right_back;
        for (int i = 0; i < bec_pkg::MOTORS; i++)
        begin
            if (s1_next.cur[i][bec_pkg::CUR_W-1])
            begin
                s1_next.mag[i] = bec_pkg::MAG_W'(0)
                               - {s1_next.cur[i][bec_pkg::CUR_W-1], s1_next.cur[i]};
            end
            else
            begin
                s1_next.mag[i] = {1'b0, s1_next.cur[i]};
            end
        end
        s1_next.full = (cmd.data.buffer_energy >= bec_pkg::BUF_W'(bec_pkg::BUF_FULL));
        s1_next.kk   = bec_pkg::K2_TABLE[cmd.data.buffer_energy[bec_pkg::BUF_IDX_W-1:0]];
    end

    always_comb
    begin
        prod           = s1_reg.kk * cfg.full_output;
        s2_next.cur    = s1_reg.cur;
        s2_next.mag    = s1_reg.mag;
        s2_next.sum    = bec_pkg::SUM_W'(s1_reg.mag[0]) + bec_pkg::SUM_W'(s1_reg.mag[1])
                       + bec_pkg::SUM_W'(s1_reg.mag[2]) + bec_pkg::SUM_W'(s1_reg.mag[3]);
        s2_next.budget = s1_reg.full ? cfg.full_output
                                     : prod[2*bec_pkg::FULL_W-1:bec_pkg::FRAC_W];
    end

    always_comb
    begin
        s3_next.cur    = s2_reg.cur;
        s3_next.mag    = s2_reg.mag;
        s3_next.sum    = s2_reg.sum;
        s3_next.budget = s2_reg.budget;
        s3_next.scaled = cfg.limit_enable
                       && (s2_reg.sum >= bec_pkg::SUM_W'(s2_reg.budget));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (adv1)
            begin
                v1_reg <= cmd.valid;
            end
            if (adv2)
            begin
                v2_reg <= v1_reg;
            end
            if (adv3)
            begin
                v3_reg <= v2_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv1)
        begin
            s1_reg <= s1_next;
        end
        if (adv2)
        begin
            s2_reg <= s2_next;
        end
        if (adv3)
        begin
            s3_reg <= s3_next;
        end
    end

    assign fwd.valid = v3_reg;
    assign fwd.data  = s3_reg;

endmodule

// ----- hdl/bec_divider.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ratio divider
// Pipelined restoring division giving budget/sum in Q1.16, three bits a stage.
// ----------------------------------------------------------------------------
module bec_divider (
    input  logic         clk,
    input  logic         rst_n,
    bec_stream_if.sink   fwd,
    bec_stream_if.source rat
);

    localparam int NSTAGE = bec_pkg::DIV_STAGES;
    localparam int PER    = bec_pkg::DIV_STEPS_PER_STAGE;
    localparam int REM_W  = bec_pkg::SUM_W;

    typedef struct packed {
        logic [bec_pkg::MOTORS-1:0][bec_pkg::CUR_W-1:0] cur;
        logic [bec_pkg::MOTORS-1:0][bec_pkg::MAG_W-1:0] mag;
        logic [bec_pkg::SUM_W-1:0]                      sum;
        logic [REM_W-1:0]                               rem;
        logic [bec_pkg::RATIO_W-1:0]                    quot;
        logic                                           scaled;
    } dstage_t;

    dstage_t          stg_reg [NSTAGE];
    logic [NSTAGE-1:0] vld_reg;
    logic [NSTAGE:0]   adv;
    dstage_t          head;

    assign adv[NSTAGE] = rat.ready;
    assign fwd.ready   = adv[0];

    always_comb
    begin
        head.cur    = fwd.data.cur;
        head.mag    = fwd.data.mag;
        head.sum    = fwd.data.sum;
        head.rem    = REM_W'(fwd.data.budget);
        head.quot   = '0;
        head.scaled = fwd.data.scaled;
    end

    for (genvar g = 0; g < NSTAGE; g++)
    begin : g_stage
        dstage_t                     src;
        dstage_t                     nxt;
        logic                        src_vld;
        logic [REM_W:0]              r;
        logic [bec_pkg::RATIO_W-1:0] q;

        if (g == 0)
        begin : g_first
            assign src     = head;
            assign src_vld = fwd.valid;
        end
        else
        begin : g_rest
            assign src     = stg_reg[g-1];
            assign src_vld = vld_reg[g-1];
        end

        assign adv[g] = !vld_reg[g] || adv[g+1];

        // The first quotient bit is the integer bit, so it takes no shift.
        always_comb
        begin
            r = {1'b0, src.rem};
            q = src.quot;
            for (int j = 0; j < PER; j++)
            begin
                if (g * PER + j < bec_pkg::RATIO_W)
                begin
                    if (g * PER + j != 0)
                    begin
                        r = {r[REM_W-1:0], 1'b0};
                    end
                    if (r >= {1'b0, src.sum})
                    begin
                        r = r - {1'b0, src.sum};
                        q = {q[bec_pkg::RATIO_W-2:0], 1'b1};
                    end
                    else
                    begin
                        q = {q[bec_pkg::RATIO_W-2:0], 1'b0};
                    end
                end
            end
            nxt        = src;
            nxt.rem    = r[REM_W-1:0];
            nxt.quot   = q;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[g] <= 1'b0;
            end
            else if (adv[g])
            begin
                vld_reg[g] <= src_vld;
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv[g])
            begin
                stg_reg[g] <= nxt;
            end
        end
    end

    assign rat.valid       = vld_reg[NSTAGE-1];
    assign rat.data.cur    = stg_reg[NSTAGE-1].cur;
    assign rat.data.mag    = stg_reg[NSTAGE-1].mag;
    assign rat.data.ratio  = stg_reg[NSTAGE-1].quot;
    assign rat.data.scaled = stg_reg[NSTAGE-1].scaled;

endmodule

// ----- hdl/bec_scale.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Current scaler
// When scaled, multiplies each magnitude by the ratio and restores the sign.
// ----------------------------------------------------------------------------
module bec_scale (
    input  logic         clk,
    input  logic         rst_n,
    bec_stream_if.sink   rat,
    bec_stream_if.source lim
);

    localparam int PROD_W = bec_pkg::MAG_W + bec_pkg::RATIO_W;

    typedef struct packed {
        logic [bec_pkg::MOTORS-1:0][bec_pkg::CUR_W-1:0] cur;
        logic [bec_pkg::MOTORS-1:0][bec_pkg::MAG_W-1:0] m;
        logic                                           scaled;
    } m_t;

    m_t                s1_reg, s1_next;
    bec_pkg::lim_t     s2_reg, s2_next;
    logic              v1_reg, v2_reg;
    logic              adv1, adv2;
    logic [PROD_W-1:0] prod [bec_pkg::MOTORS];
    logic [bec_pkg::MOTORS-1:0][bec_pkg::CUR_W-1:0] res;

    assign adv2      = !v2_reg || lim.ready;
    assign adv1      = !v1_reg || adv2;
    assign rat.ready = adv1;

    always_comb
    begin
        s1_next.cur    = rat.data.cur;
        s1_next.scaled = rat.data.scaled;
        for (int i = 0; i < bec_pkg::MOTORS; i++)
        begin
            prod[i]      = rat.data.mag[i] * rat.data.ratio;
            s1_next.m[i] = prod[i][bec_pkg::FRAC_W +: bec_pkg::MAG_W];
        end
    end

    // The scaled magnitude never exceeds the input one, so it fits back in 16 bits.
    always_comb
    begin
        for (int i = 0; i < bec_pkg::MOTORS; i++)
        begin
            if (!s1_reg.scaled)
            begin
                res[i] = s1_reg.cur[i];
            end
            else if (s1_reg.cur[i][bec_pkg::CUR_W-1])
            begin
                res[i] = bec_pkg::CUR_W'(0) - s1_reg.m[i][bec_pkg::CUR_W-1:0];
            end
            else
            begin
                res[i] = s1_reg.m[i][bec_pkg::CUR_W-1:0];
            end
        end
        s2_next.limited_left_front  = res[0];
        s2_next.limited_right_front = res[1];
        s2_next.limited_left_back   = res[2];
        s2_next.limited_right_back  = res[3];
        s2_next.was_scaled          = s1_reg.scaled;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            if (adv1)
            begin
                v1_reg <= rat.valid;
            end
            if (adv2)
            begin
                v2_reg <= v1_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv1)
        begin
            s1_reg <= s1_next;
        end
        if (adv2)
        begin
            s2_reg <= s2_next;
        end
    end

    assign lim.valid = v2_reg;
    assign lim.data  = s2_reg;

endmodule
